// ----- hdl/three_point_signed_curvature_top_defines.svh -----
// Assertion helpers shared by the curvature block.
`ifndef THREE_POINT_SIGNED_CURVATURE_TOP_DEFINES_SVH
`define THREE_POINT_SIGNED_CURVATURE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and quiet during reset.
`define TPSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and quiet during reset.
`define TPSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/tpsc_pkg.sv -----
package tpsc_pkg;

  // Operations of the shared serial unit.
  typedef enum logic [1:0] {
    OP_MUL,
    OP_SQRT,
    OP_DIV
  } tpsc_op_e;

  // Command from the sequencer to the serial unit.
  typedef struct packed {
    logic     start;
    logic     clr;
    logic     sub;
    tpsc_op_e op;
  } tpsc_cmd_t;

  // Status from the serial unit back to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } tpsc_sts_t;

endpackage

// ----- hdl/tpsc_in_if.sv -----
interface tpsc_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic               first_point;

  modport source (output valid, point_x, point_y, first_point, input ready);
  modport sink   (input valid, point_x, point_y, first_point, output ready);
endinterface

// ----- hdl/tpsc_out_if.sv -----
interface tpsc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] curvature;
  logic               degenerate;
  logic               saturated;

  modport source (output valid, curvature, degenerate, saturated, input ready);
  modport sink   (input valid, curvature, degenerate, saturated, output ready);
endinterface

// ----- hdl/three_point_signed_curvature_top.sv -----
// Signed curvature from the circle through the last three path points. Points
// come in as signed Q16.16 pairs; from the third point of a trajectory on, each
// point yields one result (1/R in Q16.16, saturated, or 0 with degenerate set
// when D is zero or 4*|D| is below collinear_threshold). The first two points
// of a trajectory are only stored and give no result. Every later point
// runs through a single shared bit-serial unit: eleven shift-add multiplies
// and three square roots of COORD_WIDTH+2 steps each, plus two restoring
// divides of max(2*COORD_WIDTH+2*FRAC_BITS+7, 64) steps (fewer in all when
// the points turn out collinear). Input is not taken while the unit works;
// a finished result waits in the output register while the next point is
// taken.
`include "three_point_signed_curvature_top_defines.svh"

module three_point_signed_curvature_top import tpsc_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_data_i,
  tpsc_in_if.sink     point_i,
  tpsc_out_if.source  result_o
);

  localparam int CW  = COORD_WIDTH;
  localparam int OW  = CW + 2;
  localparam int AW  = 2 * OW + 2;
  localparam int NW0 = AW + 2 * FRAC_BITS + 1;
  localparam int NW  = (NW0 > 64) ? NW0 : 64;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  localparam logic [3:0] ST_D0 = 4'd0;
  localparam logic [3:0] ST_D1 = 4'd1;
  localparam logic [3:0] ST_P0 = 4'd2;
  localparam logic [3:0] ST_P1 = 4'd3;
  localparam logic [3:0] ST_U0 = 4'd4;
  localparam logic [3:0] ST_U1 = 4'd5;
  localparam logic [3:0] ST_UR = 4'd6;
  localparam logic [3:0] ST_V0 = 4'd7;
  localparam logic [3:0] ST_V1 = 4'd8;
  localparam logic [3:0] ST_VR = 4'd9;
  localparam logic [3:0] ST_W0 = 4'd10;
  localparam logic [3:0] ST_W1 = 4'd11;
  localparam logic [3:0] ST_WR = 4'd12;
  localparam logic [3:0] ST_L  = 4'd13;
  localparam logic [3:0] ST_Q1 = 4'd14;
  localparam logic [3:0] ST_Q2 = 4'd15;

  // The negation stays at the difference width so the most negative value
  // turns into its full magnitude.
  function automatic logic [OW-1:0] mag_of(input logic [CW:0] d);
    logic [CW:0] neg_d;
    neg_d = -d;
    return d[CW] ? OW'(neg_d) : OW'(d);
  endfunction

  logic [1:0]  state_q, seen_q;
  logic [3:0]  stp_q;
  logic [31:0] thr_q;
  logic [CW-1:0] old_x_q, old_y_q, prv_x_q, prv_y_q;
  logic [CW:0] ux_q, uy_q, vx_q, vy_q, wx_q, wy_q;
  logic [CW:0] ux_d, uy_d, vx_d, vy_d, wx_d, wy_d;
  logic        dneg_q, dotneg_q;
  logic [AW-1:0] magd_q;
  logic [OW-1:0] lu_q, lv_q, lw_q;
  logic [31:0] pc_q, oc_q;
  logic        pd_q, ps_q, od_q, os_q, ov_q;

  logic [CW-1:0] cur_x, cur_y;
  logic [1:0]  seen_eff;
  logic        accept, full, issue, fin, fdeg, acc_neg, deg1, neg, ksat;
  logic [3:0]  nstep;
  logic [AW-1:0] acc_mag;
  logic [31:0] kval;

  tpsc_cmd_t       cmd;
  tpsc_sts_t       sts;
  logic [OW-1:0]   mul_a, mul_b;
  logic [2*OW-1:0] rad, den;
  logic [NW-1:0]   num;
  logic [AW-1:0]   acc_o;
  logic [63:0]     res_o;
  logic            over_o;

  tpsc_serial_unit #(.OW(OW), .NW(NW)) u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .mul_a_i(mul_a),
    .mul_b_i(mul_b),
    .rad_i  (rad),
    .num_i  (num),
    .den_i  (den),
    .sts_o  (sts),
    .acc_o  (acc_o),
    .res_o  (res_o),
    .over_o (over_o)
  );

  // Input side: history bookkeeping and chord vectors.
  always_comb begin
    accept   = point_i.valid && point_i.ready;
    cur_x    = CW'(point_i.point_x);
    cur_y    = CW'(point_i.point_y);
    seen_eff = point_i.first_point ? 2'd0 : seen_q;
    full     = (seen_eff == 2'd2);
    ux_d = {prv_x_q[CW-1], prv_x_q} - {old_x_q[CW-1], old_x_q};
    uy_d = {prv_y_q[CW-1], prv_y_q} - {old_y_q[CW-1], old_y_q};
    vx_d = {cur_x[CW-1], cur_x} - {old_x_q[CW-1], old_x_q};
    vy_d = {cur_y[CW-1], cur_y} - {old_y_q[CW-1], old_y_q};
    wx_d = {cur_x[CW-1], cur_x} - {prv_x_q[CW-1], prv_x_q};
    wy_d = {cur_y[CW-1], cur_y} - {prv_y_q[CW-1], prv_y_q};
  end

  // Result checks on the unit's outputs.
  always_comb begin
    acc_neg = acc_o[AW-1];
    acc_mag = acc_neg ? -acc_o : acc_o;
    deg1    = (acc_mag == '0) ||
              (((AW + 2)'(acc_mag) << 2) < (AW + 2)'(thr_q));
    neg     = dneg_q ^ dotneg_q;
    if (!neg) begin
      ksat = res_o > 64'h0000_0000_7fff_ffff;
      kval = ksat ? 32'h7fff_ffff : res_o[31:0];
    end else begin
      ksat = res_o > 64'h0000_0000_8000_0000;
      kval = ksat ? 32'h8000_0000 : -res_o[31:0];
    end
  end

  // Sequencer: decide when to start the next unit operation or finish.
  always_comb begin
    issue = 1'b0;
    fin   = 1'b0;
    fdeg  = 1'b0;
    nstep = stp_q + 4'd1;
    if (accept && full) begin
      issue = 1'b1;
      nstep = ST_D0;
    end
    if (state_q == S_RUN && sts.done) begin
      case (stp_q)
        ST_D1: begin
          if (deg1) begin
            fin  = 1'b1;
            fdeg = 1'b1;
          end else begin
            issue = 1'b1;
          end
        end
        ST_L: begin
          if (lw_q == '0 || acc_o == '0) begin
            fin  = 1'b1;
            fdeg = 1'b1;
          end else begin
            issue = 1'b1;
          end
        end
        ST_Q2: fin = 1'b1;
        default: issue = 1'b1;
      endcase
    end
  end

  // Operand selection for the step being started.
  always_comb begin
    cmd.start = issue;
    cmd.clr   = 1'b0;
    cmd.sub   = 1'b0;
    cmd.op    = OP_MUL;
    mul_a     = '0;
    mul_b     = '0;
    rad       = (2 * OW)'(acc_o);
    num       = '0;
    den       = '0;
    case (nstep)
      ST_D0: begin
        cmd.clr = 1'b1;
        cmd.sub = ux_d[CW] ^ vy_d[CW];
        mul_a   = mag_of(ux_d);
        mul_b   = mag_of(vy_d);
      end
      ST_D1: begin
        cmd.sub = !(uy_q[CW] ^ vx_q[CW]);
        mul_a   = mag_of(uy_q);
        mul_b   = mag_of(vx_q);
      end
      ST_P0: begin
        cmd.clr = 1'b1;
        cmd.sub = vx_q[CW] ^ wx_q[CW];
        mul_a   = mag_of(vx_q);
        mul_b   = mag_of(wx_q);
      end
      ST_P1: begin
        cmd.sub = vy_q[CW] ^ wy_q[CW];
        mul_a   = mag_of(vy_q);
        mul_b   = mag_of(wy_q);
      end
      ST_U0: begin
        cmd.clr = 1'b1;
        mul_a   = mag_of(ux_q);
        mul_b   = mag_of(ux_q);
      end
      ST_U1: begin
        mul_a = mag_of(uy_q);
        mul_b = mag_of(uy_q);
      end
      ST_V0: begin
        cmd.clr = 1'b1;
        mul_a   = mag_of(vx_q);
        mul_b   = mag_of(vx_q);
      end
      ST_V1: begin
        mul_a = mag_of(vy_q);
        mul_b = mag_of(vy_q);
      end
      ST_W0: begin
        cmd.clr = 1'b1;
        mul_a   = mag_of(wx_q);
        mul_b   = mag_of(wx_q);
      end
      ST_W1: begin
        mul_a = mag_of(wy_q);
        mul_b = mag_of(wy_q);
      end
      ST_UR, ST_VR, ST_WR: cmd.op = OP_SQRT;
      ST_L: begin
        cmd.clr = 1'b1;
        mul_a   = lu_q;
        mul_b   = lv_q;
      end
      ST_Q1: begin
        cmd.op = OP_DIV;
        num    = NW'(magd_q) << (2 * FRAC_BITS + 1);
        den    = (2 * OW)'(acc_o);
      end
      ST_Q2: begin
        cmd.op = OP_DIV;
        num    = NW'(over_o ? 64'hffff_ffff_ffff_ffff : res_o);
        den    = (2 * OW)'(lw_q);
      end
      default: begin
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      stp_q   <= ST_D0;
      seen_q  <= 2'd0;
      thr_q   <= 32'd429;
      ov_q    <= 1'b0;
      old_x_q <= '0;
      old_y_q <= '0;
      prv_x_q <= '0;
      prv_y_q <= '0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_data_i;
      end
      if (issue) begin
        stp_q <= nstep;
      end
      if (accept) begin
        old_x_q <= prv_x_q;
        old_y_q <= prv_y_q;
        prv_x_q <= cur_x;
        prv_y_q <= cur_y;
        seen_q  <= full ? seen_eff : seen_eff + 2'd1;
        if (full) begin
          state_q <= S_RUN;
        end
      end
      // A new result loads the output register; a taken one empties it.
      if (state_q == S_FIN && (!ov_q || result_o.ready)) begin
        ov_q <= 1'b1;
      end else if (result_o.valid && result_o.ready) begin
        ov_q <= 1'b0;
      end
      case (state_q)
        S_RUN: begin
          if (fin) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (!ov_q || result_o.ready) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers of the sequencer.
  always_ff @(posedge clk_i) begin
    if (accept && full) begin
      ux_q <= ux_d;
      uy_q <= uy_d;
      vx_q <= vx_d;
      vy_q <= vy_d;
      wx_q <= wx_d;
      wy_q <= wy_d;
    end
    if (state_q == S_RUN && sts.done) begin
      case (stp_q)
        ST_D1: begin
          dneg_q <= acc_neg;
          magd_q <= acc_mag;
        end
        ST_P1: dotneg_q <= acc_neg;
        ST_UR: lu_q <= res_o[OW-1:0];
        ST_VR: lv_q <= res_o[OW-1:0];
        ST_WR: lw_q <= res_o[OW-1:0];
        default: begin
        end
      endcase
    end
    if (fin) begin
      pc_q <= fdeg ? 32'd0 : kval;
      pd_q <= fdeg;
      ps_q <= fdeg ? 1'b0 : ksat;
    end
    if (state_q == S_FIN && (!ov_q || result_o.ready)) begin
      oc_q <= pc_q;
      od_q <= pd_q;
      os_q <= ps_q;
    end
  end

  assign point_i.ready       = (state_q == S_IDLE);
  assign result_o.valid      = ov_q;
  assign result_o.curvature  = oc_q;
  assign result_o.degenerate = od_q;
  assign result_o.saturated  = os_q;

  `TPSC_ASSERT_NOW(a_no_start_while_busy, cmd.start, !sts.busy, "unit restarted while busy")
  `TPSC_ASSERT_NEXT(a_start_makes_busy, cmd.start, sts.busy, "unit did not start")
  `TPSC_ASSERT_NOW(a_degenerate_zero, result_o.valid && result_o.degenerate,
    result_o.curvature == 32'd0 && !result_o.saturated, "degenerate result not zero")
  `TPSC_ASSERT_NOW(a_sat_at_limit, result_o.valid && result_o.saturated,
    result_o.curvature == 32'h7fff_ffff || result_o.curvature == 32'h8000_0000,
    "saturated result not at a limit")

endmodule

// ----- hdl/tpsc_serial_unit.sv -----
module tpsc_serial_unit import tpsc_pkg::*; #(
  parameter int OW = 34,
  parameter int NW = 103
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tpsc_cmd_t       cmd_i,
  input  logic [OW-1:0]   mul_a_i,
  input  logic [OW-1:0]   mul_b_i,
  input  logic [2*OW-1:0] rad_i,
  input  logic [NW-1:0]   num_i,
  input  logic [2*OW-1:0] den_i,
  output tpsc_sts_t       sts_o,
  output logic [2*OW+1:0] acc_o,
  output logic [63:0]     res_o,
  output logic            over_o
);

  localparam int AW  = 2 * OW + 2;
  localparam int RW  = 2 * OW + 1;
  localparam int CNW = $clog2(NW + 1);

  logic           busy_q, done_q;
  logic [CNW-1:0] cnt_q;
  tpsc_op_e       op_q;
  logic           sub_q;
  logic [AW-1:0]  acc_q;
  logic [2*OW-1:0] mcand_q;
  logic [OW-1:0]  mplier_q;
  logic [NW-1:0]  shf_q;
  logic [2*OW-1:0] den_q;
  logic [RW-1:0]  rem_q;
  logic [63:0]    res_q;
  logic           over_q;

  logic [AW-1:0] mul_sum;
  logic [RW-1:0] sq_sh, sq_tr, dv_sh;
  logic          sq_ge, dv_ge;

  // One step of each operation: accumulate, root digit, or quotient bit.
  always_comb begin
    mul_sum = sub_q ? acc_q - AW'(mcand_q) : acc_q + AW'(mcand_q);
    sq_sh   = {rem_q[RW-3:0], shf_q[NW-1:NW-2]};
    sq_tr   = RW'({res_q, 2'b01});
    sq_ge   = sq_sh >= sq_tr;
    dv_sh   = {rem_q[RW-2:0], shf_q[NW-1]};
    dv_ge   = dv_sh >= RW'(den_q);
  end

  // Step counter and done pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (cmd_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= (cmd_i.op == OP_DIV) ? CNW'(NW) : CNW'(OW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Operand load and datapath registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q     <= cmd_i.op;
      sub_q    <= cmd_i.sub;
      mcand_q  <= (2 * OW)'(mul_a_i);
      mplier_q <= mul_b_i;
      den_q    <= den_i;
      shf_q    <= (cmd_i.op == OP_SQRT) ? (NW'(rad_i) << (NW - 2 * OW)) : num_i;
      if (cmd_i.op == OP_MUL) begin
        if (cmd_i.clr) begin
          acc_q <= '0;
        end
      end else begin
        rem_q  <= '0;
        res_q  <= '0;
        over_q <= 1'b0;
      end
    end else if (busy_q) begin
      case (op_q)
        OP_MUL: begin
          if (mplier_q[0]) begin
            acc_q <= mul_sum;
          end
          mcand_q  <= mcand_q << 1;
          mplier_q <= mplier_q >> 1;
        end
        OP_SQRT: begin
          rem_q <= sq_ge ? sq_sh - sq_tr : sq_sh;
          res_q <= {res_q[62:0], sq_ge};
          shf_q <= shf_q << 2;
        end
        OP_DIV: begin
          rem_q  <= dv_ge ? dv_sh - RW'(den_q) : dv_sh;
          over_q <= over_q | res_q[63];
          res_q  <= {res_q[62:0], dv_ge};
          shf_q  <= shf_q << 1;
        end
        default: begin
        end
      endcase
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign acc_o      = acc_q;
  assign res_o      = res_q;
  assign over_o     = over_q;

endmodule

// ----- test/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int SETTLE_CYCLES = 1000;
  localparam logic [31:0] THRESH_RESET = 32'd429;

  typedef struct {
    logic signed [31:0] curvature;
    logic               degenerate;
    logic               saturated;
  } curv_result_t;

  // Expected curvature results, worked out from the accepted points.
  class curvature_board;
    curv_result_t       pending[$];
    logic        [31:0] collinear_thr;
    logic signed [31:0] hist_old_x, hist_old_y, hist_prev_x, hist_prev_y;
    int                 seen;
    int                 errors;

    function new();
      collinear_thr = THRESH_RESET;
      hist_old_x = 0; hist_old_y = 0; hist_prev_x = 0; hist_prev_y = 0;
      seen = 0;
      errors = 0;
    endfunction

    function automatic logic [63:0] floor_sqrt(logic [127:0] val);
      logic [63:0] root;
      logic [63:0] trial;
      root = 0;
      for (int b = 63; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if ({64'd0, trial} * {64'd0, trial} <= val) root = trial;
      end
      return root;
    endfunction

    // Fits the circle through the held points and the new one.
    function void note_point(logic signed [31:0] px, logic signed [31:0] py, logic fp);
      logic signed [127:0] ux, uy, vx, vy, wx, wy, det, dotp;
      logic        [127:0] magd, su, sv, sw, prod_len, quot;
      logic        [63:0]  lu, lv, lw, q1, mag;
      logic                neg, sat;
      curv_result_t        res;
      if (fp) seen = 0;
      if (seen < 2) begin
        hist_old_x = hist_prev_x; hist_old_y = hist_prev_y;
        hist_prev_x = px; hist_prev_y = py;
        seen++;
        return;
      end
      ux = 128'(hist_prev_x) - 128'(hist_old_x);
      uy = 128'(hist_prev_y) - 128'(hist_old_y);
      vx = 128'(px) - 128'(hist_old_x);
      vy = 128'(py) - 128'(hist_old_y);
      wx = 128'(px) - 128'(hist_prev_x);
      wy = 128'(py) - 128'(hist_prev_y);
      hist_old_x = hist_prev_x; hist_old_y = hist_prev_y;
      hist_prev_x = px; hist_prev_y = py;

      det = ux * vy - uy * vx;
      magd = (det < 0) ? -det : det;
      res.curvature = 0; res.degenerate = 1'b1; res.saturated = 1'b0;
      if (magd == 0 || (magd < (128'd1 << 62) && (magd << 2) < {96'd0, collinear_thr})) begin
        pending.insert(pending.size(), res);
        return;
      end
      dotp = vx * wx + vy * wy;
      su = ux * ux + uy * uy;
      sv = vx * vx + vy * vy;
      sw = wx * wx + wy * wy;
      lu = floor_sqrt(su); lv = floor_sqrt(sv); lw = floor_sqrt(sw);
      prod_len = {64'd0, lu} * {64'd0, lv};
      if (lw == 0 || prod_len == 0) begin
        pending.insert(pending.size(), res);
        return;
      end
      quot = (magd << 33) / prod_len;
      q1 = (quot > {64'd0, 64'hFFFF_FFFF_FFFF_FFFF}) ? 64'hFFFF_FFFF_FFFF_FFFF : quot[63:0];
      mag = q1 / lw;
      neg = (det < 0) != (dotp < 0);
      sat = 1'b0;
      if (!neg) begin
        if (mag > 64'd2147483647) begin mag = 64'd2147483647; sat = 1'b1; end
        res.curvature = mag[31:0];
      end else begin
        if (mag > 64'd2147483648) begin mag = 64'd2147483648; sat = 1'b1; end
        res.curvature = -mag[31:0];
      end
      res.degenerate = 1'b0;
      res.saturated = sat;
      pending.insert(pending.size(), res);
    endfunction

    // Compares one delivered result with the oldest expectation.
    function void check_result(logic signed [31:0] c, logic d, logic s);
      curv_result_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result curvature=%0d degenerate=%0b saturated=%0b",
                 $realtime, c, d, s);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (c !== exp_r.curvature) begin
        $display("%0t: curvature expected %0d actual %0d", $realtime, exp_r.curvature, c);
        errors++;
      end
      if (d !== exp_r.degenerate) begin
        $display("%0t: degenerate expected %0b actual %0b", $realtime, exp_r.degenerate, d);
        errors++;
      end
      if (s !== exp_r.saturated) begin
        $display("%0t: saturated expected %0b actual %0b", $realtime, exp_r.saturated, s);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_data_i = '0;
  logic        quiet = 1'b0;
  int          cycles = 0;

  tpsc_in_if  point_if ();
  tpsc_out_if result_if ();

  curvature_board board = new();

  three_point_signed_curvature_top dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_data_i(cfg_data_i),
    .point_i   (point_if.sink),
    .result_o  (result_if.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    point_if.valid = 1'b0;
    point_if.point_x = '0;
    point_if.point_y = '0;
    point_if.first_point = 1'b0;
    result_if.ready = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // Result side: check every delivered result.
  always @(posedge clk_i) begin
    if (rst_ni && result_if.valid && result_if.ready)
      board.check_result(result_if.curvature, result_if.degenerate, result_if.saturated);
  end

  // Result side: ready in random bursts, stalls stop in the quiet part.
  initial begin
    @(posedge rst_ni);
    forever begin
      result_if.ready <= 1'b1;
      repeat ($urandom_range(40, 1)) @(posedge clk_i);
      if (!quiet && $urandom_range(2, 0) == 0) begin
        result_if.ready <= 1'b0;
        repeat ($urandom_range(17, 1)) @(posedge clk_i);
      end
    end
  end

  // Presents one point request and holds it until the block takes it.
  task automatic send_point(logic signed [31:0] px, logic signed [31:0] py, logic fp);
    point_if.valid <= 1'b1;
    point_if.point_x <= px;
    point_if.point_y <= py;
    point_if.first_point <= fp;
    do @(posedge clk_i); while (!point_if.ready);
    board.note_point(px, py, fp);
    if (!quiet && $urandom_range(3, 0) == 0) begin
      point_if.valid <= 1'b0;
      repeat ($urandom_range(17, 1)) @(posedge clk_i);
    end
  endtask

  // Lets everything drain, then idles on for points that give no result.
  task automatic drain();
    point_if.valid <= 1'b0;
    @(posedge clk_i);
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [31:0] val);
    drain();
    cfg_we_i <= 1'b1;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.collinear_thr = val;
  endtask

  function automatic logic signed [31:0] rand_coord();
    logic signed [31:0] v;
    v = $urandom();
    return v;
  endfunction

  // Random trajectories: mostly scattered points around one centre,
  // each trajectory at one scale, with some collinear runs and some loose noise.
  task automatic random_points(int count);
    logic signed [31:0] cx, cy, dx, dy;
    int                 len, kind, span;
    int                 sent;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(9, 0);
      len = $urandom_range(9, 3);
      cx = rand_coord();
      cy = rand_coord();
      case ($urandom_range(3, 0))
        0: span = 4;
        1: span = 12;
        2: span = 20;
        default: span = 30;
      endcase
      if (kind == 0) begin
        // Noise: unrelated points with random restarts.
        for (int i = 0; i < len; i++)
          send_point(rand_coord(), rand_coord(), $urandom_range(4, 0) == 0);
      end else if (kind == 1) begin
        // Points on one line.
        dx = $signed($urandom()) >>> (32 - span);
        dy = $signed($urandom()) >>> (32 - span);
        for (int i = 0; i < len; i++)
          send_point(cx + dx * i, cy + dy * i, i == 0);
      end else begin
        for (int i = 0; i < len; i++) begin
          dx = $signed($urandom()) >>> (32 - span);
          dy = $signed($urandom()) >>> (32 - span);
          send_point(cx + dx, cy + dy, i == 0);
        end
      end
      sent += len;
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: three points on a circle of radius one, then a repeat.
    send_point(32'sh0001_0000, 32'sh0000_0000, 1'b1);
    send_point(32'sh0000_0000, 32'sh0001_0000, 1'b0);
    send_point(-32'sh0001_0000, 32'sh0000_0000, 1'b0);
    send_point(32'sh0000_0000, 32'sh0001_0000, 1'b0);
    // Sharp turn that runs back almost to the start point.
    send_point(32'sh0000_0000, 32'sh0000_0000, 1'b1);
    send_point(32'sh0010_0000, 32'sh0000_0000, 1'b0);
    send_point(32'sh0000_0000, 32'sh0000_0001, 1'b0);
    // Repeated point and exactly collinear points.
    send_point(32'sh0000_0000, 32'sh0000_0001, 1'b0);
    send_point(32'sh0003_0000, 32'sh0003_0001, 1'b1);
    send_point(32'sh0004_0000, 32'sh0004_0001, 1'b0);
    send_point(32'sh0005_0000, 32'sh0005_0001, 1'b0);
    // Tiny circle that clips, then the coordinate extremes.
    send_point(32'sh0000_0000, 32'sh0000_0000, 1'b1);
    send_point(32'sh0000_0001, 32'sh0000_0000, 1'b0);
    send_point(32'sh0000_0000, 32'sh0000_0001, 1'b0);
    send_point(32'sh0000_0001, 32'sh0000_0001, 1'b0);
    send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1);
    send_point(32'sh8000_0000, 32'sh8000_0000, 1'b0);
    send_point(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
    send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
    send_point(32'shFFFF_FFFF, 32'sh0000_0000, 1'b0);

    // Threshold at zero: only an exact zero determinant counts as collinear.
    write_threshold(32'd0);
    send_point(32'sh0000_0000, 32'sh0000_0000, 1'b1);
    send_point(32'sh0000_0001, 32'sh0000_0000, 1'b0);
    send_point(32'sh0000_0002, 32'sh0000_0001, 1'b0);
    send_point(32'sh0000_0002, 32'sh0000_0001, 1'b0);
    random_points(60);

    // Threshold at the top: most small triangles become collinear.
    write_threshold(32'hFFFF_FFFF);
    random_points(80);

    write_threshold($urandom());
    random_points(120);

    write_threshold(THRESH_RESET);
    random_points(120);

    // Hold the sender back until every result is in.
    drain();
    write_threshold($urandom_range(4096, 0));
    random_points(70);

    // Last part with no stalls on either side.
    quiet = 1'b1;
    random_points(100);

    point_if.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+hdl
hdl/tpsc_pkg.sv
hdl/tpsc_in_if.sv
hdl/tpsc_out_if.sv
hdl/tpsc_serial_unit.sv
hdl/three_point_signed_curvature_top.sv
test/tb.sv
